// File: design/ckblit_pkg.sv
// ----------------------------------------------------------------------------
// ckblit_pkg
// Types and constants shared by the color-key sprite blitter and its channels.
// ----------------------------------------------------------------------------
package ckblit_pkg;

  localparam int PixelW    = 16;
  localparam int ScreenW   = 12;
  localparam int BgIndexW  = 23;
  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 16;

  typedef enum logic [1:0] {
    ACT_SET_CURSOR  = 2'd0,
    ACT_WRITE_PIXEL = 2'd1,
    ACT_COPY_BG     = 2'd2
  } action_e;

  localparam logic [CfgIndexW-1:0] REG_ORIGIN_X      = 4'd0;
  localparam logic [CfgIndexW-1:0] REG_ORIGIN_Y      = 4'd1;
  localparam logic [CfgIndexW-1:0] REG_SPRITE_WIDTH  = 4'd2;
  localparam logic [CfgIndexW-1:0] REG_SPRITE_HEIGHT = 4'd3;
  localparam logic [CfgIndexW-1:0] REG_SCREEN_WIDTH  = 4'd4;
  localparam logic [CfgIndexW-1:0] REG_SCREEN_HEIGHT = 4'd5;
  localparam logic [CfgIndexW-1:0] REG_TOP_CLIP_ROW  = 4'd6;
  localparam logic [CfgIndexW-1:0] REG_KEY_COLOR     = 4'd7;

  localparam logic [ScreenW-1:0] ScreenWidthRst  = 12'd480;
  localparam logic [ScreenW-1:0] ScreenHeightRst = 12'd800;
  localparam logic [PixelW-1:0]  KeyColorRst     = 16'hFFFF;
  localparam int                 TopClipRst      = 24;

  typedef struct packed {
    logic [PixelW-1:0] sprite_pixel;
  } pix_t;

  typedef struct packed {
    action_e             action;
    logic [ScreenW-1:0]  cursor_x;
    logic [ScreenW-1:0]  cursor_y;
    logic [PixelW-1:0]   pixel_value;
    logic [BgIndexW-1:0] background_index;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;
  } cfg_t;

endpackage

// File: design/ckblit_if.sv
// ----------------------------------------------------------------------------
// ckblit_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ckblit_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/color_key_sprite_blit.sv
// ----------------------------------------------------------------------------
// color_key_sprite_blit
// Turns a bottom-up sprite pixel stream into cursor, pixel-write and
// background-copy actions for a display controller, with color keying.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                     handshake
//  px_i      in    sprite_pixel                                valid/ready
//  res_o     out   action, cursor_x/y, pixel_value,            valid/ready
//                  background_index, last
//  cfg_i     in    index, data (register write)                valid/ready
//
//  A pixel transaction yields zero to three actions, all computed in the
//  accepting cycle and held in a three-entry result register.
//  One action leaves per cycle while res_o.ready is high. px_i.ready is high
//  when the result register is empty or empties in that cycle, so a new pixel
//  waits for the earlier actions to leave. Configuration writes are always taken.
//  Reset loads the register defaults and puts the counters at the window start.
module color_key_sprite_blit #(
  parameter int COORD_BITS = 11
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ckblit_if.sink       px_i,
  ckblit_if.source     res_o,
  ckblit_if.sink       cfg_i
);

  localparam int CW = COORD_BITS + 1;
  localparam int OW = (COORD_BITS < 11) ? COORD_BITS : 11;
  localparam int LW = ((COORD_BITS > ckblit_pkg::ScreenW) ? COORD_BITS
                       : ckblit_pkg::ScreenW) + 2;
  localparam int SW = ckblit_pkg::ScreenW;
  localparam int BW = ckblit_pkg::BgIndexW;

  logic [OW-1:0]     ox_q, ox_d, oy_q, oy_d, top_q, top_d;
  logic [SW-1:0]     spw_q, spw_d, sph_q, sph_d, scw_q, scw_d, sch_q, sch_d;
  logic [ckblit_pkg::PixelW-1:0] key_q, key_d;
  logic              cfg_hit;

  logic [CW-1:0]     col_q, col_d, row_q, row_d;
  logic [1:0]        cnt_q, cnt_d;
  ckblit_pkg::res_t  slot_q [3];
  ckblit_pkg::res_t  slot_n [3];
  ckblit_pkg::res_t  cand   [3];
  logic [2:0]        pres;
  logic [1:0]        n_res;

  logic              px_acc, pop;
  logic              row_start, visible, row_end, sprite_end;
  logic [LW-1:0]     row_last_col;
  logic [SW-1:0]     eff_w, eff_h_d, bg_rows;
  logic [CW-1:0]     col_rst, row_rst;
  logic [ckblit_pkg::PixelW-1:0] pix;

  assign cfg_i.ready = 1'b1;
  assign pop         = res_o.valid && res_o.ready;
  assign px_i.ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && res_o.ready);
  assign px_acc      = px_i.valid && px_i.ready;
  assign pix         = px_i.data.sprite_pixel;

  always_comb begin
    ox_d    = ox_q;
    oy_d    = oy_q;
    spw_d   = spw_q;
    sph_d   = sph_q;
    scw_d   = scw_q;
    sch_d   = sch_q;
    top_d   = top_q;
    key_d   = key_q;
    cfg_hit = 1'b0;
    if (cfg_i.valid) begin
      cfg_hit = 1'b1;
      unique case (cfg_i.data.index)
        ckblit_pkg::REG_ORIGIN_X:      ox_d  = cfg_i.data.data[OW-1:0];
        ckblit_pkg::REG_ORIGIN_Y:      oy_d  = cfg_i.data.data[OW-1:0];
        ckblit_pkg::REG_SPRITE_WIDTH:  spw_d = cfg_i.data.data[SW-1:0];
        ckblit_pkg::REG_SPRITE_HEIGHT: sph_d = cfg_i.data.data[SW-1:0];
        ckblit_pkg::REG_SCREEN_WIDTH:  scw_d = cfg_i.data.data[SW-1:0];
        ckblit_pkg::REG_SCREEN_HEIGHT: sch_d = cfg_i.data.data[SW-1:0];
        ckblit_pkg::REG_TOP_CLIP_ROW:  top_d = cfg_i.data.data[OW-1:0];
        ckblit_pkg::REG_KEY_COLOR:     key_d = cfg_i.data.data;
        default:                       cfg_hit = 1'b0;
      endcase
    end
  end

  // Window start for the geometry in effect after this cycle.
  assign eff_h_d = (sph_d == '0) ? SW'(1) : sph_d;
  assign col_rst = CW'(ox_d);
  assign row_rst = CW'(LW'(oy_d) + LW'(eff_h_d) - LW'(1));

  assign eff_w        = (spw_q == '0) ? SW'(1) : spw_q;
  assign row_last_col = LW'(ox_q) + LW'(eff_w) - LW'(1);
  assign row_start    = (col_q == CW'(ox_q));
  assign visible      = (LW'(row_q) >= LW'(top_q)) && (LW'(row_q) < LW'(sch_q));
  assign row_end      = (LW'(col_q) >= row_last_col);
  assign sprite_end   = row_end && (LW'(row_q) <= LW'(oy_q));
  assign bg_rows      = sch_q - SW'(1) - SW'(row_q);

  always_comb begin
    cand[0]          = '0;
    cand[0].action   = ckblit_pkg::ACT_SET_CURSOR;
    cand[0].cursor_x = SW'(col_q);
    cand[0].cursor_y = SW'(row_q);

    cand[1] = '0;
    if (pix != key_q) begin
      cand[1].action      = ckblit_pkg::ACT_WRITE_PIXEL;
      cand[1].pixel_value = pix;
    end else begin
      cand[1].action           = ckblit_pkg::ACT_COPY_BG;
      cand[1].background_index = BW'((2*SW)'(scw_q) * (2*SW)'(bg_rows)) + BW'(col_q);
    end

    cand[2]          = '0;
    cand[2].action   = ckblit_pkg::ACT_SET_CURSOR;
    cand[2].cursor_x = scw_q - SW'(1);
    cand[2].cursor_y = sch_q - SW'(1);
    cand[2].last     = 1'b1;
  end

  assign pres  = {sprite_end, visible, row_start};
  assign n_res = 2'(pres[0]) + 2'(pres[1]) + 2'(pres[2]);

  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    for (int i = 0; i < 3; i++) begin
      slot_n[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      if (pres[i]) begin
        slot_n[k] = cand[i];
        k         = k + 2'd1;
      end
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cnt_d = cnt_q;
    if (px_acc) begin
      cnt_d = n_res;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
    if (cfg_hit) begin
      col_d = col_rst;
      row_d = row_rst;
    end else if (px_acc) begin
      if (row_end) begin
        if (sprite_end) begin
          col_d = col_rst;
          row_d = row_rst;
        end else begin
          col_d = CW'(ox_q);
          row_d = row_q - CW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q  <= '0;
      oy_q  <= '0;
      spw_q <= SW'(1);
      sph_q <= SW'(1);
      scw_q <= ckblit_pkg::ScreenWidthRst;
      sch_q <= ckblit_pkg::ScreenHeightRst;
      top_q <= OW'(ckblit_pkg::TopClipRst);
      key_q <= ckblit_pkg::KeyColorRst;
      col_q <= '0;
      row_q <= '0;
      cnt_q <= 2'd0;
    end else begin
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      spw_q <= spw_d;
      sph_q <= sph_d;
      scw_q <= scw_d;
      sch_q <= sch_d;
      top_q <= top_d;
      key_q <= key_d;
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (px_acc) begin
      slot_q[0] <= slot_n[0];
      slot_q[1] <= slot_n[1];
      slot_q[2] <= slot_n[2];
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

  assign res_o.valid = (cnt_q != 2'd0);
  assign res_o.data  = slot_q[0];

`ifndef SYNTHESIS
  a_last_is_park: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.last) |->
      (res_o.data.action == ckblit_pkg::ACT_SET_CURSOR))
    else $error("last transaction is not a cursor set");

  a_park_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (px_acc && sprite_end) |=> (col_q == CW'(ox_q)))
    else $error("column not back at window start after sprite end");

  a_row_start_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (px_acc && row_start) |=>
      (res_o.valid && res_o.data.action == ckblit_pkg::ACT_SET_CURSOR))
    else $error("row start without a leading cursor set");

  a_no_accept_with_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (px_acc && cnt_q != 2'd0) |-> (pop && cnt_q == 2'd1))
    else $error("pixel accepted while earlier actions remain queued");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the color-key sprite blitter. A directed table walks
// the reset state, the clipping rules, zero sizes and index overflow, then
// random register settings and random sprites follow under changing handshake
// pressure. Every action is checked against the table or a local model of the blitter.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  SettleCycles   = 4;
  localparam int  WatchdogLimit  = 3000;
  localparam int  HoldCycles     = 300;
  localparam int  HoldPhase      = 4;
  localparam int  Phases         = 16;
  localparam int  PixelsPerPhase = 30;
  localparam int  RegCount       = 8;
  localparam int  Predicted      = -1;
  localparam int  DirectedRows   = 39;
  localparam int  PrintLimit     = 25;

  localparam logic [ckblit_pkg::CfgIndexW-1:0] REG_UNUSED = 4'd9;

  localparam ckblit_pkg::res_t NO_ACT       = '0;
  localparam ckblit_pkg::res_t SET_TOP_LEFT =
    '{ckblit_pkg::ACT_SET_CURSOR, 12'd0, 12'd0, 16'd0, 23'd0, 1'b0};
  localparam ckblit_pkg::res_t SET_ROW_100  =
    '{ckblit_pkg::ACT_SET_CURSOR, 12'd0, 12'd100, 16'd0, 23'd0, 1'b0};
  localparam ckblit_pkg::res_t SET_EDGE_100 =
    '{ckblit_pkg::ACT_SET_CURSOR, 12'd2047, 12'd100, 16'd0, 23'd0, 1'b0};
  localparam ckblit_pkg::res_t PARK_DEFAULT =
    '{ckblit_pkg::ACT_SET_CURSOR, 12'd479, 12'd799, 16'd0, 23'd0, 1'b1};
  localparam ckblit_pkg::res_t PARK_WRAP    =
    '{ckblit_pkg::ACT_SET_CURSOR, 12'd4095, 12'd4095, 16'd0, 23'd0, 1'b1};
  localparam ckblit_pkg::res_t WRITE_0000   =
    '{ckblit_pkg::ACT_WRITE_PIXEL, 12'd0, 12'd0, 16'h0000, 23'd0, 1'b0};
  localparam ckblit_pkg::res_t WRITE_1234   =
    '{ckblit_pkg::ACT_WRITE_PIXEL, 12'd0, 12'd0, 16'h1234, 23'd0, 1'b0};
  localparam ckblit_pkg::res_t WRITE_FFFF   =
    '{ckblit_pkg::ACT_WRITE_PIXEL, 12'd0, 12'd0, 16'hFFFF, 23'd0, 1'b0};
  localparam ckblit_pkg::res_t COPY_ROW_100 =
    '{ckblit_pkg::ACT_COPY_BG, 12'd0, 12'd0, 16'd0, 23'd335520, 1'b0};
  localparam ckblit_pkg::res_t NO_ACTS [3]  = '{NO_ACT, NO_ACT, NO_ACT};

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                        kind;
    logic [ckblit_pkg::CfgIndexW-1:0] index;
    logic [15:0]                      value;
    int                               n_want;
    ckblit_pkg::res_t                 want [3];
  } dir_row_t;

  dir_row_t directed_rows [DirectedRows] = '{
    '{ROW_PIXEL, '0, 16'h0000, 2, '{SET_TOP_LEFT, PARK_DEFAULT, NO_ACT}},
    '{ROW_PIXEL, '0, 16'hFFFF, 2, '{SET_TOP_LEFT, PARK_DEFAULT, NO_ACT}},
    '{ROW_REG, ckblit_pkg::REG_ORIGIN_Y, 16'd100, 0, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h1234, 3, '{SET_ROW_100, WRITE_1234, PARK_DEFAULT}},
    '{ROW_PIXEL, '0, 16'hFFFF, 3, '{SET_ROW_100, COPY_ROW_100, PARK_DEFAULT}},
    '{ROW_PIXEL, '0, 16'h0000, 3, '{SET_ROW_100, WRITE_0000, PARK_DEFAULT}},
    '{ROW_REG, ckblit_pkg::REG_KEY_COLOR, 16'h0000, 0, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h0000, 3, '{SET_ROW_100, COPY_ROW_100, PARK_DEFAULT}},
    '{ROW_PIXEL, '0, 16'hFFFF, 3, '{SET_ROW_100, WRITE_FFFF, PARK_DEFAULT}},
    '{ROW_REG, ckblit_pkg::REG_ORIGIN_X, 16'h07FF, 0, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_SPRITE_WIDTH, 16'd3, 0, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_SPRITE_HEIGHT, 16'd2, 0, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h0000, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h8001, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h0000, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h7FFE, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h5555, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'hAAAA, Predicted, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_TOP_CLIP_ROW, 16'd101, 0, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h0001, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h0000, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h4000, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h0000, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'hFFFE, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h2AAA, Predicted, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_SCREEN_HEIGHT, 16'd0, 0, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_SCREEN_WIDTH, 16'd0, 0, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_SPRITE_WIDTH, 16'd0, 0, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_SPRITE_HEIGHT, 16'd0, 0, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h0000, 2, '{SET_EDGE_100, PARK_WRAP, NO_ACT}},
    '{ROW_REG, REG_UNUSED, 16'hFFFF, 0, NO_ACTS},
    '{ROW_PIXEL, '0, 16'hFFFF, 2, '{SET_EDGE_100, PARK_WRAP, NO_ACT}},
    '{ROW_REG, ckblit_pkg::REG_ORIGIN_X, 16'd0, 0, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_ORIGIN_Y, 16'd0, 0, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_TOP_CLIP_ROW, 16'd0, 0, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_SCREEN_WIDTH, 16'h0FFF, 0, NO_ACTS},
    '{ROW_REG, ckblit_pkg::REG_SCREEN_HEIGHT, 16'h0FFF, 0, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h0000, Predicted, NO_ACTS},
    '{ROW_PIXEL, '0, 16'h1234, Predicted, NO_ACTS}
  };

  int gap_by_mode   [4] = '{0, 85, 0, 15};
  int stall_by_mode [4] = '{0, 0, 85, 15};

  logic clk_i;
  logic rst_ni;

  ckblit_if #(.payload_t(ckblit_pkg::pix_t)) px_ch ();
  ckblit_if #(.payload_t(ckblit_pkg::res_t)) res_ch ();
  ckblit_if #(.payload_t(ckblit_pkg::cfg_t)) cfg_ch ();

  color_key_sprite_blit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .px_i   (px_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  logic [10:0] org_x, org_y, clip_row;
  logic [11:0] spr_w, spr_h, scr_w, scr_h;
  logic [15:0] key;
  logic [11:0] col_q, row_q;

  ckblit_pkg::res_t pending_actions [$];
  int   action_errors = 0;
  int   gap_pct       = 0;
  int   stall_pct     = 0;
  int   hold_requests = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void window_start();
    col_q = 12'(org_x);
    row_q = 12'(32'(org_y) + ((spr_h == 0) ? 32'd1 : 32'(spr_h)) - 32'd1);
  endfunction

  function automatic void load_defaults();
    org_x    = '0;
    org_y    = '0;
    spr_w    = 12'd1;
    spr_h    = 12'd1;
    scr_w    = ckblit_pkg::ScreenWidthRst;
    scr_h    = ckblit_pkg::ScreenHeightRst;
    clip_row = 11'(ckblit_pkg::TopClipRst);
    key      = ckblit_pkg::KeyColorRst;
    window_start();
  endfunction

  function automatic void apply_reg(input logic [ckblit_pkg::CfgIndexW-1:0] idx,
                                    input logic [15:0] v);
    bit hit;
    hit = 1'b1;
    case (idx)
      ckblit_pkg::REG_ORIGIN_X:      org_x = v[10:0];
      ckblit_pkg::REG_ORIGIN_Y:      org_y = v[10:0];
      ckblit_pkg::REG_SPRITE_WIDTH:  spr_w = v[11:0];
      ckblit_pkg::REG_SPRITE_HEIGHT: spr_h = v[11:0];
      ckblit_pkg::REG_SCREEN_WIDTH:  scr_w = v[11:0];
      ckblit_pkg::REG_SCREEN_HEIGHT: scr_h = v[11:0];
      ckblit_pkg::REG_TOP_CLIP_ROW:  clip_row = v[10:0];
      ckblit_pkg::REG_KEY_COLOR:     key = v;
      default:                       hit = 1'b0;
    endcase
    if (hit) window_start();
  endfunction

  function automatic void blit_pixel(input logic [15:0] pix, input bit keep);
    int unsigned      last_col;
    int unsigned      bg_idx;
    ckblit_pkg::res_t acts [$];
    last_col = 32'(org_x) + ((spr_w == 0) ? 32'd1 : 32'(spr_w)) - 32'd1;
    if (col_q == 12'(org_x))
      acts.push_back(ckblit_pkg::res_t'{ckblit_pkg::ACT_SET_CURSOR, col_q, row_q, 16'd0,
                                        23'd0, 1'b0});
    if (row_q >= 12'(clip_row) && row_q < scr_h) begin
      if (pix != key) begin
        acts.push_back(ckblit_pkg::res_t'{ckblit_pkg::ACT_WRITE_PIXEL, 12'd0, 12'd0, pix,
                                          23'd0, 1'b0});
      end else begin
        bg_idx = 32'(scr_w) * (32'(scr_h) - 32'd1 - 32'(row_q)) + 32'(col_q);
        acts.push_back(ckblit_pkg::res_t'{ckblit_pkg::ACT_COPY_BG, 12'd0, 12'd0, 16'd0,
                                          bg_idx[22:0], 1'b0});
      end
    end
    if (32'(col_q) >= last_col) begin
      if (row_q <= 12'(org_y)) begin
        acts.push_back(ckblit_pkg::res_t'{ckblit_pkg::ACT_SET_CURSOR, scr_w - 12'd1,
                                          scr_h - 12'd1, 16'd0, 23'd0, 1'b1});
        window_start();
      end else begin
        col_q = 12'(org_x);
        row_q = row_q - 12'd1;
      end
    end else begin
      col_q = col_q + 12'd1;
    end
    if (keep) foreach (acts[i]) pending_actions.push_back(acts[i]);
  endfunction

  function automatic logic [15:0] pick_reg_value(
      input logic [ckblit_pkg::CfgIndexW-1:0] idx);
    logic [15:0] v;
    if ($urandom_range(9) == 0) return 16'($urandom);
    case (idx)
      ckblit_pkg::REG_ORIGIN_X:
        v = ($urandom_range(3) == 0) ? 16'(2047 * $urandom_range(1)) : 16'($urandom_range(2047));
      ckblit_pkg::REG_ORIGIN_Y:
        v = ($urandom_range(3) == 0) ? 16'(2047 * $urandom_range(1)) : 16'($urandom_range(1000));
      ckblit_pkg::REG_SPRITE_WIDTH:  v = 16'($urandom_range(6));
      ckblit_pkg::REG_SPRITE_HEIGHT: v = 16'($urandom_range(5));
      ckblit_pkg::REG_SCREEN_WIDTH:
        v = ($urandom_range(4) == 0) ? 16'(2048 * $urandom_range(1)) :
                                       16'($urandom_range(2048, 1));
      ckblit_pkg::REG_SCREEN_HEIGHT:
        v = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom_range(2048, 32'(org_y) + 1));
      ckblit_pkg::REG_TOP_CLIP_ROW:
        v = ($urandom_range(5) == 0) ? 16'd2047 : 16'($urandom_range(32'(org_y), 0));
      default:           v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_pixel();
    return ($urandom_range(99) < 40) ? key : 16'($urandom);
  endfunction

  task automatic flag_action_error(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
    action_errors++;
    if (action_errors <= PrintLimit)
      $display("tb_top: %0t %s got 0x%0h wanted 0x%0h", $time, what, got, want);
  endtask

  task automatic send_pixel(input logic [15:0] pix, input bit predicted);
    if ($urandom_range(99) < gap_pct) begin
      px_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    px_ch.valid <= 1'b1;
    px_ch.data  <= ckblit_pkg::pix_t'(pix);
    do @(posedge clk_i); while (!px_ch.ready);
    blit_pixel(pix, predicted);
  endtask

  task automatic write_reg(input logic [ckblit_pkg::CfgIndexW-1:0] idx,
                           input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, data: v};
    do @(posedge clk_i); while (!cfg_ch.ready);
    apply_reg(idx, v);
  endtask

  task automatic settle();
    px_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int hold_left;
    int holds_seen;
    hold_left    = 0;
    holds_seen   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_actions
    ckblit_pkg::res_t got;
    ckblit_pkg::res_t want;
    if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = res_ch.data;
      if (pending_actions.size() == 0) begin
        flag_action_error("action with none pending", 32'(got.action), 32'hFFFF_FFFF);
      end else begin
        want = pending_actions.pop_front();
        if (got.action !== want.action)
          flag_action_error("action", 32'(got.action), 32'(want.action));
        if (got.cursor_x !== want.cursor_x)
          flag_action_error("cursor_x", 32'(got.cursor_x), 32'(want.cursor_x));
        if (got.cursor_y !== want.cursor_y)
          flag_action_error("cursor_y", 32'(got.cursor_y), 32'(want.cursor_y));
        if (got.pixel_value !== want.pixel_value)
          flag_action_error("pixel_value", 32'(got.pixel_value), 32'(want.pixel_value));
        if (got.background_index !== want.background_index)
          flag_action_error("background_index", 32'(got.background_index),
                            32'(want.background_index));
        if (got.last !== want.last)
          flag_action_error("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((px_ch.valid === 1'b1 && px_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top: no transaction for %0d cycles", WatchdogLimit);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    px_ch.valid  = 1'b0;
    px_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rst_ni       = 1'b0;
    load_defaults();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (i > 0 && directed_rows[i - 1].kind == ROW_PIXEL) settle();
        write_reg(directed_rows[i].index, directed_rows[i].value);
        if (i + 1 == DirectedRows || directed_rows[i + 1].kind == ROW_PIXEL)
          cfg_ch.valid <= 1'b0;
      end else begin
        send_pixel(directed_rows[i].value, directed_rows[i].n_want == Predicted);
        for (int j = 0; j < directed_rows[i].n_want; j++)
          pending_actions.push_back(directed_rows[i].want[j]);
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      gap_pct   = gap_by_mode[ph % 4];
      stall_pct = stall_by_mode[ph % 4];
      for (int r = 0; r < RegCount; r++)
        write_reg(ckblit_pkg::CfgIndexW'(r), pick_reg_value(ckblit_pkg::CfgIndexW'(r)));
      if ($urandom_range(4) == 0)
        write_reg(ckblit_pkg::CfgIndexW'($urandom_range(15, RegCount)), 16'($urandom));
      cfg_ch.valid <= 1'b0;
      for (int k = 0; k < PixelsPerPhase; k++) begin
        if (ph == HoldPhase && k == 8) hold_requests++;
        send_pixel(pick_pixel(), 1'b1);
      end
    end

    settle();
    if (action_errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
